// ===== sv/b2d_pkg.sv =====
// shared constants for the binary to decimal digit splitter
// no dependencies; imported by binary_to_decimal_digits_core
package b2d_pkg;

	localparam int DEF_VALUE_WIDTH = 32;
	localparam int DEF_MAX_DIGITS  = 10;

	// one bcd digit and the output byte that carries it
	localparam int DIGIT_W   = 4;
	localparam int OUT_TDATA_W = 8;

	// binary bits shifted into the bcd register per pipeline stage
	localparam int BITS_PER_STAGE = 4;

	// a digit at or above this value is corrected before each shift
	localparam logic [DIGIT_W-1:0] ADJ_LIMIT = DIGIT_W'(5);
	localparam logic [DIGIT_W-1:0] ADJ_ADD   = DIGIT_W'(3);

endpackage

// ===== sv/binary_to_decimal_digits_core.sv =====
// Binary to decimal digit splitter: pipelined shift-and-add-3 conversion, then a digit serialiser.
// The first digit is offered once the value has passed the conversion stages, the count stage and the serialiser.
// Output: one digit per cycle while m_tready is high; an item gives as many digits as it has (1 to MAX_DIGITS),
// all through the single output port. Inputs enter each cycle while the pipe flows.
// Reset: arst_n clears all valid bits and the serialiser; the digit registers hold no reset.
// Uses b2d_pkg.
module binary_to_decimal_digits_core #(
	parameter int VALUE_WIDTH = b2d_pkg::DEF_VALUE_WIDTH,
	parameter int MAX_DIGITS  = b2d_pkg::DEF_MAX_DIGITS
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [((VALUE_WIDTH+7)/8)*8-1:0]    s_tdata,  // value
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [b2d_pkg::OUT_TDATA_W-1:0]     m_tdata,  // digit, zero pad
	output logic                                m_tlast   // last
);

	import b2d_pkg::*;

	localparam int NST   = (VALUE_WIDTH + BITS_PER_STAGE - 1) / BITS_PER_STAGE;
	localparam int PAD_W = NST * BITS_PER_STAGE;
	localparam int BCD_W = MAX_DIGITS * DIGIT_W;
	localparam int IDX_W = $clog2(MAX_DIGITS);

	typedef struct packed {
		logic             ovf;
		logic [BCD_W-1:0] bcd;
		logic [PAD_W-1:0] bin;
	} dab_t;

	// BITS_PER_STAGE bits of shift-and-add-3; digits above the kept ones only leave a sticky flag
	function automatic dab_t dab_step(dab_t x);
		dab_t             y;
		logic [DIGIT_W-1:0] d;
		y = x;
		for (int b = 0; b < BITS_PER_STAGE; b++) begin
			for (int i = 0; i < MAX_DIGITS; i++) begin
				d = y.bcd[i*DIGIT_W +: DIGIT_W];
				if (d >= ADJ_LIMIT) begin
					y.bcd[i*DIGIT_W +: DIGIT_W] = d + ADJ_ADD;
				end
			end
			y.ovf = y.ovf | y.bcd[BCD_W-1];
			y.bcd = {y.bcd[BCD_W-2:0], y.bin[PAD_W-1]};
			y.bin = {y.bin[PAD_W-2:0], 1'b0};
		end
		return y;
	endfunction

	// conversion stages
	logic        vld_s [NST+1];
	dab_t        dab_s [NST+1];
	logic        rdy   [1:NST+1];

	// count stage
	logic                 cnt_vld_s;
	logic [BCD_W-1:0]     cnt_bcd_s;
	logic [IDX_W-1:0]     cnt_top_s;
	logic [IDX_W-1:0]     top_idx;

	// serialiser
	logic                 busy_q;
	logic [IDX_W-1:0]     idx_q;
	logic [DIGIT_W-1:0]   digits_q [MAX_DIGITS];
	logic                 ser_take;

	assign vld_s[0]     = s_tvalid;
	assign dab_s[0].ovf = 1'b0;
	assign dab_s[0].bcd = '0;
	assign dab_s[0].bin = PAD_W'(s_tdata[VALUE_WIDTH-1:0]);
	assign s_tready     = rdy[1];

	for (genvar k = 1; k <= NST; k++) begin : g_stage
		assign rdy[k] = !vld_s[k] || rdy[k+1];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (rdy[k]) begin
				vld_s[k] <= vld_s[k-1];
			end
		end

		always_ff @(posedge clk) begin
			if (rdy[k] && vld_s[k-1]) begin
				dab_s[k] <= dab_step(dab_s[k-1]);
			end
		end
	end

	// highest significant digit; a sticky overflow means the stack is filled
	always_comb begin
		top_idx = '0;
		for (int i = 1; i < MAX_DIGITS; i++) begin
			if (dab_s[NST].bcd[i*DIGIT_W +: DIGIT_W] != '0) begin
				top_idx = IDX_W'(i);
			end
		end
		if (dab_s[NST].ovf) begin
			top_idx = IDX_W'(MAX_DIGITS - 1);
		end
	end

	assign ser_take    = !busy_q || (m_tready && idx_q == '0);
	assign rdy[NST+1]  = !cnt_vld_s || ser_take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_vld_s <= 1'b0;
		end else if (rdy[NST+1]) begin
			cnt_vld_s <= vld_s[NST];
		end
	end

	always_ff @(posedge clk) begin
		if (rdy[NST+1] && vld_s[NST]) begin
			cnt_bcd_s <= dab_s[NST].bcd;
			cnt_top_s <= top_idx;
		end
	end

	// pop from the top digit down to the units
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
		end else if (ser_take) begin
			busy_q <= cnt_vld_s;
			if (cnt_vld_s) begin
				idx_q <= cnt_top_s;
			end
		end else if (m_tready) begin
			idx_q <= idx_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ser_take && cnt_vld_s) begin
			for (int i = 0; i < MAX_DIGITS; i++) begin
				digits_q[i] <= cnt_bcd_s[i*DIGIT_W +: DIGIT_W];
			end
		end
	end

	assign m_tvalid = busy_q;
	assign m_tdata  = OUT_TDATA_W'(digits_q[idx_q]);
	assign m_tlast  = (idx_q == '0);

endmodule
